/* design/pbs_pkg.sv */
// Shared types and constants for the PolyBLEP sawtooth oscillator.
package pbs_pkg;

  localparam int unsigned PhaseW  = 32;
  localparam int unsigned SampleW = 16;

  // Reset value of the reciprocal sample rate register: 1/48000 in Q0.32.
  localparam logic [PhaseW-1:0] InvSrReset = 32'd89478;

  // Which side of the wrap discontinuity a sample falls on.
  typedef enum logic [1:0] {
    EDGE_NONE,
    EDGE_RISE,
    EDGE_FALL
  } edge_kind_e;

  // One queued sample job: front end to back end.
  typedef struct packed {
    edge_kind_e        kind;
    logic [PhaseW-1:0] phase;
    logic [PhaseW-1:0] inc;
    logic [PhaseW-1:0] numer;
  } job_t;

endpackage

/* design/pbs_front.sv */
// Front end: phase increment multiply, edge classification and phase accumulator.
module pbs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pbs_pkg::PhaseW-1:0]    inv_sample_rate_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pbs_pkg::PhaseW-1:0]    frequency_i,
  input  logic                          full_i,
  output logic                          push_o,
  output pbs_pkg::job_t                 job_o
);
  import pbs_pkg::*;

  logic                    s1_valid_q, s1_valid_d;
  logic [PhaseW-1:0]       inc_q;
  logic [PhaseW-1:0]       phase_q;
  logic [2*PhaseW-1:0]     prod;
  logic [PhaseW:0]         sum;
  logic                    accept;

  // Q16.16 * Q0.32 = Q16.48; keep the fractional Q0.32 part
  assign prod   = (2*PhaseW)'(frequency_i) * (2*PhaseW)'(inv_sample_rate_i);
  assign sum    = {1'b0, phase_q} + {1'b0, inc_q};

  assign push_o     = s1_valid_q && !full_i;
  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !push_o);

  always_comb begin
    job_o.phase = phase_q;
    job_o.inc   = inc_q;
    job_o.kind  = EDGE_NONE;
    job_o.numer = '0;
    if (inc_q != '0) begin
      if (phase_q < inc_q) begin
        job_o.kind  = EDGE_RISE;
        job_o.numer = phase_q;
      end else if (sum[PhaseW] && (sum[PhaseW-1:0] != '0)) begin
        // phase is nonzero here, so one minus phase fits the word
        job_o.kind  = EDGE_FALL;
        job_o.numer = '0 - phase_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (push_o) begin
        phase_q <= sum[PhaseW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inc_q <= prod[PhaseW+15:16];
    end
  end

endmodule

/* design/pbs_fifo.sv */
// Small job queue decoupling the front end from the divider back end.
module pbs_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbs_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pbs_pkg::job_t data_o
);
  import pbs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

/* design/pbs_back.sv */
// Back end: radix-2 divider, BLEP square, output rounding and saturation.
module pbs_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  pbs_pkg::job_t                       job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pbs_pkg::SampleW-1:0]  sample_o
);
  import pbs_pkg::*;

  localparam int unsigned DivSteps = PhaseW;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);
  localparam int unsigned VW       = PhaseW + 4;
  localparam int unsigned ShW      = VW - 17;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SQR,
    S_FIN
  } state_e;

  state_e                     state_q;
  logic                       out_valid_q;
  logic signed [SampleW-1:0]  sample_q;

  job_t                       job_q;
  logic [PhaseW-1:0]          rem_q, quo_q;
  logic [CntW-1:0]            cnt_q;
  logic [PhaseW:0]            sq_q;

  logic [PhaseW:0]            trial;
  logic                       ge;
  logic [PhaseW-1:0]          rem_next;
  logic [PhaseW:0]            u;
  logic [PhaseW-1:0]          h;
  logic [2*PhaseW-1:0]        hh;
  logic signed [VW-1:0]       v;
  logic signed [ShW-1:0]      sh;
  logic signed [SampleW-1:0]  sat;
  logic                       out_free;

  // restoring divide step: numerator * 2^32 / inc, numerator < inc
  assign trial    = {rem_q, 1'b0};
  assign ge       = trial >= {1'b0, job_q.inc};
  assign rem_next = ge ? PhaseW'(trial - {1'b0, job_q.inc}) : trial[PhaseW-1:0];

  // (1 - q)^2 in Q0.32 via the halved operand
  assign u  = {1'b1, {PhaseW{1'b0}}} - {1'b0, quo_q};
  assign h  = u[PhaseW:1];
  assign hh = (2*PhaseW)'(h) * (2*PhaseW)'(h);

  always_comb begin
    v = $signed({3'b000, job_q.phase, 1'b0}) - $signed(VW'({1'b1, {PhaseW{1'b0}}}));
    case (job_q.kind)
      EDGE_RISE: v = v + $signed(VW'(sq_q));
      EDGE_FALL: v = v - $signed(VW'(sq_q));
      default:   v = v;
    endcase
    // round to nearest, ties up, Q.32 -> Q.15
    sh = ShW'((v + $signed(VW'(32'd65536))) >>> 17);
    if (sh > $signed(ShW'(16'sh7fff))) begin
      sat = 16'sh7fff;
    end else if (sh < -$signed(ShW'(17'h08000))) begin
      sat = -16'sh7fff - 16'sh0001;
    end else begin
      sat = sh[SampleW-1:0];
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else begin
      // a finishing job reloads the output register in S_FIN instead
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            state_q <= (job_i.kind == EDGE_NONE) ? S_SQR : S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == CntLast) begin
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            sample_q    <= sat;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          job_q <= job_i;
          rem_q <= job_i.numer;
          quo_q <= '0;
          cnt_q <= '0;
        end
      end
      S_DIV: begin
        rem_q <= rem_next;
        quo_q <= {quo_q[PhaseW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      S_SQR: begin
        sq_q <= (job_q.kind == EDGE_NONE) ? '0 : hh[2*PhaseW-2:30];
      end
      default: ;
    endcase
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < job_q.inc))
    else $error("divider remainder not below divisor");

  a_div_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && $past(state_q) == S_IDLE) |-> (cnt_q == '0))
    else $error("divide entered with stale step count");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_DIV || state_q == S_SQR))
    else $error("popped job did not start");

endmodule

/* design/polyblep_saw_oscillator.sv */
// Top level of the PolyBLEP band-limited sawtooth oscillator.
// The back end computes a sample near the wrap edge with a 32-step radix-2 divider and
//   skips the divider for a plain ramp sample; it works on one queued job at a time.
// The back-end divider sets the rate; the front end takes one transaction per cycle while
//   the queue is not full, so it accepts new samples while the divider is still busy.
// Reset: asynchronous, active low; clears phase to zero, empties the queue, drops
//   result valid and loads inv_sample_rate with 1/48000 (Q0.32).
module polyblep_saw_oscillator #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: reciprocal sample rate, Q0.32
  input  logic                                inv_sample_rate_we_i,
  input  logic [pbs_pkg::PhaseW-1:0]          inv_sample_rate_i,
  // input channel: one frequency (Q16.16 Hz) per sample period
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pbs_pkg::PhaseW-1:0]          frequency_i,
  // output channel: Q1.15 sample
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pbs_pkg::SampleW-1:0]  sample_o
);
  import pbs_pkg::*;

  logic [PhaseW-1:0] inv_sample_rate_q;

  logic  push, pop, full, empty;
  job_t  front_job, back_job;

  // Config register; the user must write it only while the datapath is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_sample_rate_q <= InvSrReset;
    end else if (inv_sample_rate_we_i) begin
      inv_sample_rate_q <= inv_sample_rate_i;
    end
  end

  // Front end: inc = freq * inv_sr, classify against the wrap edge, advance phase.
  // The phase accumulator only needs inc, so it runs ahead of the divider.
  pbs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .inv_sample_rate_i(inv_sample_rate_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .frequency_i      (frequency_i),
    .full_i           (full),
    .push_o           (push),
    .job_o            (front_job)
  );

  // Job queue between the two halves.
  pbs_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_job),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (back_job)
  );

  // Back end: edge position by division, residual square, round and saturate.
  // The output register lets the divider start the next job while a result waits.
  pbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (back_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sample_o   (sample_o)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the PolyBLEP sawtooth oscillator.
module testbench;
  import pbs_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainPause = 40;    // long enough for a near-edge sample to drain
  localparam int unsigned LongHold   = 400;
  localparam int unsigned PhaseItems = 113;
  localparam int unsigned RatePhases = 10;
  localparam bit [63:0]   QOne       = 64'h1_0000_0000;

  typedef enum logic { ROW_TONE, ROW_RATE } row_kind_e;

  // One directed step: a frequency transaction or a rate register write.
  // A set "fixed" flag means the sample is known by inspection and typed in.
  typedef struct packed {
    row_kind_e           kind;
    logic [31:0]         value;
    logic                fixed;
    logic signed [15:0]  sample;
  } stim_row_t;

  stim_row_t directed_rows [0:23] = '{
    '{ROW_TONE, 32'h0000_0000, 1'b1, 16'sh8000},  // zero increment: bare ramp at -1
    '{ROW_TONE, 32'h0001_0000, 1'b1, 16'sh0000},  // 1 Hz from phase 0: full rising fix-up
    '{ROW_TONE, 32'h0000_0001, 1'b0, 16'sh0},
    '{ROW_TONE, 32'hFFFF_FFFF, 1'b0, 16'sh0},     // increment wraps past one
    '{ROW_TONE, 32'h8000_0000, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h5DC0_0000, 1'b0, 16'sh0},     // 24 kHz: increment near one half
    '{ROW_TONE, 32'h7FFF_FFFF, 1'b0, 16'sh0},
    '{ROW_RATE, 32'h0000_0000, 1'b0, 16'sh0},     // rate zero: no correction at all
    '{ROW_TONE, 32'hFFFF_FFFF, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h1234_5678, 1'b0, 16'sh0},
    '{ROW_RATE, 32'hFFFF_FFFF, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h0001_0000, 1'b0, 16'sh0},     // increment just under one: edges overlap
    '{ROW_TONE, 32'h0001_0000, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h0000_8000, 1'b0, 16'sh0},
    '{ROW_TONE, 32'hFFFF_FFFF, 1'b0, 16'sh0},
    '{ROW_TONE, 32'hAAAA_AAAA, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h5555_5555, 1'b0, 16'sh0},
    '{ROW_RATE, 32'h8000_0000, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h0002_0000, 1'b0, 16'sh0},     // increment exactly one wraps to zero
    '{ROW_TONE, 32'h0001_0001, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h0001_FFFF, 1'b0, 16'sh0},
    '{ROW_RATE, 32'h0001_5D86, 1'b0, 16'sh0},     // back to 48 kHz
    '{ROW_TONE, 32'h01B8_0000, 1'b0, 16'sh0},
    '{ROW_TONE, 32'h01B8_0000, 1'b0, 16'sh0}
  };

  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b0;
  logic                inv_sample_rate_we_i = 1'b0;
  logic [PhaseW-1:0]   inv_sample_rate_i    = '0;
  logic                in_valid_i           = 1'b0;
  logic                in_stall_o;
  logic [PhaseW-1:0]   frequency_i          = '0;
  logic                out_valid_o;
  logic                out_stall_i          = 1'b0;
  logic signed [SampleW-1:0] sample_o;

  // predictor state
  logic [31:0] osc_phase = '0;
  logic [31:0] rate_q032 = InvSrReset;

  logic signed [15:0] pending_samples [$];

  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned tones_sent      = 0;
  int unsigned samples_checked = 0;
  int unsigned rate_writes     = 0;
  int unsigned rise_hits       = 0;
  int unsigned fall_hits       = 0;
  int unsigned clipped         = 0;
  bit          tx_burst        = 1'b0;
  bit          rx_burst        = 1'b0;
  bit          long_hold_done  = 1'b0;

  polyblep_saw_oscillator uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .inv_sample_rate_we_i (inv_sample_rate_we_i),
    .inv_sample_rate_i    (inv_sample_rate_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .frequency_i          (frequency_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .sample_o             (sample_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Next band-limited sample for one frequency; advances the predicted phase.
  function automatic logic signed [15:0] saw_sample(input logic [31:0] freq);
    bit [63:0]  prod;
    bit [31:0]  inc;
    bit [63:0]  quot;
    bit [63:0]  half;
    bit [63:0]  resid;
    bit [63:0]  biased;
    longint     ramp;
    longint     s;
    edge_kind_e side;
    prod  = {32'b0, freq} * {32'b0, rate_q032};
    inc   = prod[47:16];             // integer bits of the Q16.48 product drop out
    ramp  = 2 * longint'(osc_phase) - longint'(QOne);
    side  = EDGE_NONE;
    resid = '0;
    if (inc != 0) begin
      // rising side wins when the two regions overlap
      if (osc_phase < inc) begin
        side = EDGE_RISE;
        quot = {osc_phase, 32'b0} / {32'b0, inc};
      end else if ({32'b0, osc_phase} + {32'b0, inc} > QOne) begin
        side = EDGE_FALL;
        quot = (QOne - {32'b0, osc_phase}) << 32;
        quot = quot / {32'b0, inc};
      end
      if (side != EDGE_NONE) begin
        half  = (QOne - quot) >> 1;
        resid = (half * half) >> 30;
      end
    end
    if (side == EDGE_RISE) begin
      ramp = ramp + longint'(resid);
      rise_hits++;
    end else if (side == EDGE_FALL) begin
      ramp = ramp - longint'(resid);
      fall_hits++;
    end
    // Q.32 to Q1.15, round half up
    biased = ramp + 64'sd17179869184 + 64'sd65536;
    s = longint'(biased >> 17) - 131072;
    if (s > 32767 || s < -32768) clipped++;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    osc_phase = osc_phase + inc;
    return s[15:0];
  endfunction

  function automatic logic [31:0] draw_frequency();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1, 2, 3: return $urandom_range(0, 32'd1310720000);   // up to 20 kHz
      4:       return $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
      5:       return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] draw_rate();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return InvSrReset;
      3:       return 32'd97391;        // 44.1 kHz
      4:       return 32'd44739;        // 96 kHz
      default: return $urandom();
    endcase
  endfunction

  // Offer one frequency until taken, queue its sample, then maybe idle.
  task automatic send_tone(input logic [31:0] freq, input logic fixed,
                           input logic signed [15:0] fixed_sample);
    logic signed [15:0] predicted;
    int unsigned        gap;
    in_valid_i  <= 1'b1;
    frequency_i <= freq;
    do @(posedge clk_i); while (in_stall_o);
    predicted = saw_sample(freq);
    pending_samples.push_back(fixed ? fixed_sample : predicted);
    tones_sent++;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Register writes only with the block drained and settled.
  task automatic write_rate(input logic [31:0] value);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
    inv_sample_rate_we_i <= 1'b1;
    inv_sample_rate_i    <= value;
    @(posedge clk_i);
    inv_sample_rate_we_i <= 1'b0;
    rate_q032 = value;
    rate_writes++;
  endtask

  // Output side: random hold-offs, one long one early on, and the compare.
  initial begin : sample_sink
    int unsigned hold;
    logic signed [15:0] want;
    wait (rst_ni);
    forever begin
      if (!long_hold_done && samples_checked == 80) begin
        hold = LongHold;       // sender keeps going; queue fills and input stalls
        long_hold_done = 1'b1;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_samples.size() == 0) begin
        $error("sample transaction with nothing expected: sample=%0d", sample_o);
        mismatch_count++;
      end else begin
        want = pending_samples.pop_front();
        if (sample_o !== want) begin
          $error("sample mismatch: expected %0d, actual %0d", want, sample_o);
          mismatch_count++;
        end
      end
      samples_checked++;
    end
  end

  initial begin : stimulus
    int unsigned in_phase;
    int unsigned seg_len;
    logic [31:0] tone;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_RATE) write_rate(directed_rows[i].value);
      else send_tone(directed_rows[i].value, directed_rows[i].fixed,
                     directed_rows[i].sample);
    end

    // Random part: mostly steady tones that sweep the phase through the wrap,
    // with single-sample noise mixed in.
    for (int p = 0; p < RatePhases; p++) begin
      write_rate(draw_rate());
      in_phase = 0;
      while (in_phase < PhaseItems) begin
        tone    = draw_frequency();
        seg_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
        if (seg_len > PhaseItems - in_phase) seg_len = PhaseItems - in_phase;
        repeat (seg_len) send_tone(tone, 1'b0, 16'sh0);
        in_phase += seg_len;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);

    $display("Covered %0d frequency transactions under %0d rate writes; %0d samples checked.",
             tones_sent, rate_writes, samples_checked);
    $display("Edge fix-ups: %0d rising, %0d falling; %0d samples clipped at full scale.",
             rise_hits, fall_hits, clipped);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
design/pbs_pkg.sv
design/pbs_front.sv
design/pbs_fifo.sv
design/pbs_back.sv
design/polyblep_saw_oscillator.sv
dv/testbench.sv
